// ===== rtl/core/comm_aware_greedy_mapper_macros.svh =====
// Assertion macros used by the mapper's datapath.
`ifndef COMM_AWARE_GREEDY_MAPPER_MACROS_SVH
`define COMM_AWARE_GREEDY_MAPPER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CAGM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CAGM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cagm_pkg.sv =====
// Types, constants and helpers shared by the mapper's controller and datapath.
package cagm_pkg;

   localparam int MAX_OBJECTS = 64;
   localparam int MAX_PES     = 16;
   localparam int MAX_EDGES   = 256;

   localparam int OBJ_W    = 6;
   localparam int PE_W     = 4;
   localparam int LOAD_W   = 56;
   localparam int WEIGHT_W = 48;
   localparam int BYTE_W   = 32;
   localparam int MSG_W    = 24;
   localparam int EIDX_W   = 8;
   localparam int ECNT_W   = 9;
   localparam int OCNT_W   = 7;
   localparam int PCNT_W   = 5;
   localparam int COST_W   = 32;
   localparam int MSUM_W   = 32;
   localparam int BSUM_W   = 40;
   localparam int PROD_W   = 64;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 72;

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   localparam logic [PCNT_W-1:0] PE_COUNT_RESET  = 5'd16;
   localparam logic [COST_W-1:0] MSG_COST_RESET  = 32'd38482906;
   localparam logic [COST_W-1:0] BYTE_COST_RESET = 32'd9346;

   localparam logic [CSR_IDX_W-1:0] CSR_PE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_COST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_COST = 2'd2;

   typedef enum logic [1:0] {
      OP_OBJECT = 2'd0,
      OP_EDGE   = 2'd1,
      OP_RUN    = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEL,
      S_SCAN,
      S_PE_SET,
      S_MUL_MSG,
      S_MUL_BLO,
      S_MUL_BHI,
      S_BSUM,
      S_COST,
      S_TOTAL,
      S_CMP,
      S_PREP,
      S_PLACE,
      S_CLEAR
   } state_type;

   typedef struct packed {
      logic ld_obj;
      logic ld_edge;
      logic sel_start;
      logic sel_run;
      logic scan_start;
      logic scan_run;
      logic pe_set;
      logic mul_msg;
      logic mul_blo;
      logic mul_bhi;
      logic bsum;
      logic cost;
      logic total;
      logic cmp;
      logic pe_next;
      logic prep;
      logic place;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic sel_done;
      logic scan_done;
      logic pe_last;
      logic run_last;
      logic out_free;
      logic no_objects;
   } status_type;

   function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                 input logic [LOAD_W-1:0] b);
      logic [LOAD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
   endfunction

endpackage

// ===== rtl/core/cagm_ctrl.sv =====
// Sequencer for loading, placement steps and the end-of-run clear.
module cagm_ctrl
   import cagm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_opcode,
   input  logic       req_from_remote,
   input  logic       req_to_remote,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      accept     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept && req_opcode == OP_OBJECT) begin
               cmd.ld_obj = 1'b1;
            end
            // edges flagged remote on either end are dropped outright
            if (accept && req_opcode == OP_EDGE && !req_from_remote && !req_to_remote) begin
               cmd.ld_edge = 1'b1;
            end
            if (accept && req_opcode == OP_RUN) begin
               if (status.no_objects) begin
                  state_in = S_CLEAR;
               end else begin
                  cmd.sel_start = 1'b1;
                  state_in      = S_SEL;
               end
            end
         end
         S_SEL: begin
            cmd.sel_run = 1'b1;
            if (status.sel_done) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = S_PE_SET;
            end
         end
         S_PE_SET: begin
            cmd.pe_set = 1'b1;
            state_in   = S_MUL_MSG;
         end
         S_MUL_MSG: begin
            cmd.mul_msg = 1'b1;
            state_in    = S_MUL_BLO;
         end
         S_MUL_BLO: begin
            cmd.mul_blo = 1'b1;
            state_in    = S_MUL_BHI;
         end
         S_MUL_BHI: begin
            cmd.mul_bhi = 1'b1;
            state_in    = S_BSUM;
         end
         S_BSUM: begin
            cmd.bsum = 1'b1;
            state_in = S_COST;
         end
         S_COST: begin
            cmd.cost = 1'b1;
            state_in = S_TOTAL;
         end
         S_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            if (status.pe_last) begin
               state_in = S_PREP;
            end else begin
               cmd.pe_next = 1'b1;
               state_in    = S_PE_SET;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_PLACE;
         end
         S_PLACE: begin
            if (status.out_free) begin
               cmd.place = 1'b1;
               if (status.run_last) begin
                  state_in = S_CLEAR;
               end else begin
                  cmd.sel_start = 1'b1;
                  state_in      = S_SEL;
               end
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/cagm_dpath.sv =====
// Stores, selection scan, edge cost scan, shared multiplier and result register.
`include "comm_aware_greedy_mapper_macros.svh"
module cagm_dpath
   import cagm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [OBJ_W-1:0]       obj_a,
   input  logic [OBJ_W-1:0]       obj_b,
   input  logic [PE_W-1:0]        home_pe,
   input  logic [WEIGHT_W-1:0]    obj_load,
   input  logic [BYTE_W-1:0]      byte_total,
   input  logic [MSG_W-1:0]       msg_total,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COST_W-1:0]      csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   // configuration
   logic [PCNT_W-1:0] pe_count_ff;
   logic [COST_W-1:0] msg_cost_ff, byte_cost_ff;
   logic [PE_W-1:0]   npe_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_count_ff  <= PE_COUNT_RESET;
         msg_cost_ff  <= MSG_COST_RESET;
         byte_cost_ff <= BYTE_COST_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PE_COUNT:  pe_count_ff  <= csr_data[PCNT_W-1:0];
            CSR_MSG_COST:  msg_cost_ff  <= csr_data;
            CSR_BYTE_COST: byte_cost_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pe_count_ff == '0) begin
         npe_m1 = '0;
      end else if (pe_count_ff > PCNT_W'(MAX_PES)) begin
         npe_m1 = PE_W'(MAX_PES - 1);
      end else begin
         npe_m1 = PE_W'(pe_count_ff - PCNT_W'(1));
      end
   end

   // object and edge stores
   logic [MAX_OBJECTS-1:0] loaded_ff, placed_ff;
   logic [OCNT_W-1:0]      obj_count_ff, k_ff;
   logic [ECNT_W-1:0]      edge_count_ff;
   logic                   overflow_ff;
   logic                   edge_full;

   logic [WEIGHT_W-1:0] weight_mem [MAX_OBJECTS];
   logic [PE_W-1:0]     home_mem   [MAX_OBJECTS];
   logic [PE_W-1:0]     dest_mem   [MAX_OBJECTS];
   logic [OBJ_W-1:0]    snd_mem    [MAX_EDGES];
   logic [OBJ_W-1:0]    rcv_mem    [MAX_EDGES];
   logic [BYTE_W-1:0]   byte_mem   [MAX_EDGES];
   logic [MSG_W-1:0]    msg_mem    [MAX_EDGES];

   // selection scan
   logic [OCNT_W-1:0]   sel_idx_ff;
   logic                sel_v_ff, found_ff;
   logic [OBJ_W-1:0]    sel_id_ff, best_idx_ff;
   logic [WEIGHT_W-1:0] weight_rd_ff, best_w_ff;
   logic [PE_W-1:0]     home_rd_ff;
   logic                cand;

   // edge scan
   logic [ECNT_W-1:0] e_idx_ff;
   logic              v1_ff, v2_ff;
   logic [OBJ_W-1:0]  e_snd_rd_ff, e_rcv_rd_ff, nb;
   logic [BYTE_W-1:0] e_byte_rd_ff, b2_ff;
   logic [MSG_W-1:0]  e_msg_rd_ff, m2_ff;
   logic [PE_W-1:0]   dest_rd_ff;
   logic              hit_s, hit_r;
   logic [MSUM_W-1:0] tot_m_ff, on_m_ff [MAX_PES];
   logic [BSUM_W-1:0] tot_b_ff, on_b_ff [MAX_PES];
   logic [PE_W-1:0]   on_addr;
   logic [MSUM_W-1:0] on_m_sel;
   logic [BSUM_W-1:0] on_b_sel;

   // processor loop
   logic [PE_W-1:0]   pe_idx_ff, bp_ff;
   logic [MSUM_W-1:0] msgs_ff;
   logic [BSUM_W-1:0] bytes_ff;
   logic [LOAD_W-1:0] pe_load_ff [MAX_PES];
   logic [LOAD_W-1:0] pload_ff, msat_ff, bsat_ff, cost_ff, tot_ff;
   logic [LOAD_W-1:0] btot_ff, bcost_ff, bload_ff, acc_ff, new_load;
   logic [COST_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod, mprod_ff, blo_ff, bhi_ff;
   logic [PROD_W:0]   bsum;

   // result register
   logic                   rsp_v_ff, rsp_last_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   assign edge_full = edge_count_ff == ECNT_W'(MAX_EDGES);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         loaded_ff     <= '0;
         placed_ff     <= '0;
         obj_count_ff  <= '0;
         edge_count_ff <= '0;
         overflow_ff   <= 1'b0;
         k_ff          <= '0;
      end else begin
         if (cmd.ld_obj) begin
            loaded_ff[obj_a] <= 1'b1;
            if (!loaded_ff[obj_a]) begin
               obj_count_ff <= obj_count_ff + OCNT_W'(1);
            end
         end
         if (cmd.ld_edge) begin
            if (edge_full) begin
               overflow_ff <= 1'b1;
            end else begin
               edge_count_ff <= edge_count_ff + ECNT_W'(1);
            end
         end
         if (cmd.place) begin
            placed_ff[best_idx_ff] <= 1'b1;
            k_ff                   <= k_ff + OCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_obj) begin
         weight_mem[obj_a] <= obj_load;
         home_mem[obj_a]   <= home_pe;
      end
      weight_rd_ff <= weight_mem[sel_idx_ff[OBJ_W-1:0]];
      home_rd_ff   <= home_mem[best_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_edge && !edge_full) begin
         snd_mem[edge_count_ff[EIDX_W-1:0]]  <= obj_a;
         rcv_mem[edge_count_ff[EIDX_W-1:0]]  <= obj_b;
         byte_mem[edge_count_ff[EIDX_W-1:0]] <= byte_total;
         msg_mem[edge_count_ff[EIDX_W-1:0]]  <= msg_total;
      end
      e_snd_rd_ff  <= snd_mem[e_idx_ff[EIDX_W-1:0]];
      e_rcv_rd_ff  <= rcv_mem[e_idx_ff[EIDX_W-1:0]];
      e_byte_rd_ff <= byte_mem[e_idx_ff[EIDX_W-1:0]];
      e_msg_rd_ff  <= msg_mem[e_idx_ff[EIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         dest_mem[best_idx_ff] <= bp_ff;
      end
      dest_rd_ff <= dest_mem[nb];
   end

   // heaviest unplaced object, first index wins on equal weight
   assign cand = loaded_ff[sel_id_ff] && !placed_ff[sel_id_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_idx_ff <= '0;
         sel_v_ff   <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.sel_start) begin
         sel_idx_ff <= '0;
         sel_v_ff   <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.sel_run) begin
         sel_v_ff <= sel_idx_ff != OCNT_W'(MAX_OBJECTS);
         if (sel_idx_ff != OCNT_W'(MAX_OBJECTS)) begin
            sel_idx_ff <= sel_idx_ff + OCNT_W'(1);
         end
         if (sel_v_ff && cand && (!found_ff || weight_rd_ff > best_w_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_id_ff <= sel_idx_ff[OBJ_W-1:0];
      if (cmd.sel_run && sel_v_ff && cand && (!found_ff || weight_rd_ff > best_w_ff)) begin
         best_idx_ff <= sel_id_ff;
         best_w_ff   <= weight_rd_ff;
      end
   end

   // neighbour of the object being placed on this edge, if any
   assign hit_s = e_snd_rd_ff == best_idx_ff;
   assign hit_r = e_rcv_rd_ff == best_idx_ff;
   assign nb    = hit_s ? e_rcv_rd_ff : e_snd_rd_ff;

   assign on_addr  = cmd.scan_run ? dest_rd_ff : pe_idx_ff;
   assign on_m_sel = on_m_ff[on_addr];
   assign on_b_sel = on_b_ff[on_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_idx_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else if (cmd.scan_start) begin
         e_idx_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else if (cmd.scan_run) begin
         v1_ff <= e_idx_ff != edge_count_ff;
         if (e_idx_ff != edge_count_ff) begin
            e_idx_ff <= e_idx_ff + ECNT_W'(1);
         end
         v2_ff <= v1_ff && (hit_s || hit_r) && placed_ff[nb];
      end
   end

   // totals over all placed neighbours, and per processor; cost(p) = total - on(p)
   always_ff @(posedge clock) begin
      m2_ff <= e_msg_rd_ff;
      b2_ff <= e_byte_rd_ff;
      if (cmd.scan_start) begin
         tot_m_ff <= '0;
         tot_b_ff <= '0;
         for (int q = 0; q < MAX_PES; q++) begin
            on_m_ff[q] <= '0;
            on_b_ff[q] <= '0;
         end
      end else if (cmd.scan_run && v2_ff) begin
         tot_m_ff            <= tot_m_ff + MSUM_W'(m2_ff);
         tot_b_ff            <= tot_b_ff + BSUM_W'(b2_ff);
         on_m_ff[dest_rd_ff] <= on_m_sel + MSUM_W'(m2_ff);
         on_b_ff[dest_rd_ff] <= on_b_sel + BSUM_W'(b2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_idx_ff <= '0;
      end else if (cmd.scan_start) begin
         pe_idx_ff <= '0;
      end else if (cmd.pe_next) begin
         pe_idx_ff <= pe_idx_ff + PE_W'(1);
      end
   end

   // one shared 32x32 multiplier: messages, low byte word, high byte bits
   always_comb begin
      mul_a = cmd.mul_msg ? msg_cost_ff : byte_cost_ff;
      if (cmd.mul_msg) begin
         mul_b = msgs_ff;
      end else if (cmd.mul_blo) begin
         mul_b = bytes_ff[COST_W-1:0];
      end else begin
         mul_b = COST_W'(bytes_ff[BSUM_W-1:COST_W]);
      end
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign bsum = {1'b0, blo_ff} + {9'b0, bhi_ff[23:0], 32'b0};

   always_ff @(posedge clock) begin
      if (cmd.pe_set) begin
         msgs_ff  <= tot_m_ff - on_m_sel;
         bytes_ff <= tot_b_ff - on_b_sel;
         pload_ff <= pe_load_ff[pe_idx_ff];
      end
      if (cmd.mul_msg) mprod_ff <= prod;
      if (cmd.mul_blo) blo_ff <= prod;
      if (cmd.mul_bhi) bhi_ff <= prod;
      if (cmd.bsum) begin
         msat_ff <= (|mprod_ff[PROD_W-1:LOAD_W]) ? LOAD_MAX : mprod_ff[LOAD_W-1:0];
         bsat_ff <= ((|bhi_ff[PROD_W-1:24]) || (|bsum[PROD_W:LOAD_W])) ?
                    LOAD_MAX : bsum[LOAD_W-1:0];
      end
      if (cmd.cost) cost_ff <= sat_add(msat_ff, bsat_ff);
      if (cmd.total) tot_ff <= sat_add(pload_ff, cost_ff);
      if (cmd.cmp && (pe_idx_ff == '0 || tot_ff < btot_ff)) begin
         bp_ff    <= pe_idx_ff;
         btot_ff  <= tot_ff;
         bcost_ff <= cost_ff;
         bload_ff <= pload_ff;
      end
      if (cmd.prep) acc_ff <= sat_add(LOAD_W'(best_w_ff), bcost_ff);
   end

   assign new_load = sat_add(bload_ff, acc_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int q = 0; q < MAX_PES; q++) begin
            pe_load_ff[q] <= '0;
         end
      end else if (cmd.place) begin
         pe_load_ff[bp_ff] <= new_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (cmd.place) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         rsp_data_ff <= {overflow_ff, new_load, home_rd_ff != bp_ff, bp_ff,
                         home_rd_ff, best_idx_ff};
         rsp_last_ff <= OCNT_W'(k_ff + OCNT_W'(1)) == obj_count_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.sel_done   = sel_idx_ff == OCNT_W'(MAX_OBJECTS) && !sel_v_ff;
   assign status.scan_done  = e_idx_ff == edge_count_ff && !v1_ff && !v2_ff;
   assign status.pe_last    = pe_idx_ff == npe_m1;
   assign status.run_last   = OCNT_W'(k_ff + OCNT_W'(1)) == obj_count_ff;
   assign status.out_free   = !rsp_v_ff || rsp_tready;
   assign status.no_objects = obj_count_ff == '0;

   `CAGM_ASSERT_IMP(a_place_slot, cmd.place, !rsp_v_ff || rsp_tready, "result slot busy at placement")
   `CAGM_ASSERT_IMP(a_dest_range, cmd.place, bp_ff <= npe_m1, "destination beyond processor count")
   `CAGM_ASSERT_IMP(a_sel_found, cmd.scan_start, found_ff, "cost scan without a selected object")
   `CAGM_ASSERT_NEXT(a_clear_empty, cmd.clear, obj_count_ff == '0 && edge_count_ff == '0 && k_ff == '0, "stores not empty after clear")

endmodule

// ===== rtl/core/comm_aware_greedy_mapper.sv =====
// Top level of the communication-aware greedy mapper.
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   req_tdata, req_tuser (opcode)
//  rsp      out  rsp_tvalid/rsp_tready   rsp_tdata, rsp_tlast
//  csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// Object and edge records are accepted only while idle. Per placed object, a run
// scans all object slots to select, scans the stored edges to sum traffic to placed
// neighbours, costs each processor through the shared multiplier, then prepares and
// places it; a clear ends the run. Reset is synchronous and clears all control state.
// A placement waits while the result register is full and not taken.
module comm_aware_greedy_mapper
   import cagm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // obj_a, obj_b, home_pe, obj_load, byte_total, msg_total, from_remote, to_remote
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // object, source_pe, dest_pe, moved, dest_load, capacity_lost
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COST_W-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cagm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_opcode      (req_tuser),
      .req_from_remote (req_tdata[120]),
      .req_to_remote   (req_tdata[121]),
      .status          (status),
      .cmd             (cmd)
   );

   cagm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .obj_a      (req_tdata[5:0]),
      .obj_b      (req_tdata[11:6]),
      .home_pe    (req_tdata[15:12]),
      .obj_load   (req_tdata[63:16]),
      .byte_total (req_tdata[95:64]),
      .msg_total  (req_tdata[119:96]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
